[sv/tsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants of the token scanner: character classes, queue
// entries, token kinds and the keyword table.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_DECIMAL = 3'd2;
  localparam logic [2:0] KIND_OCTAL   = 3'd3;
  localparam logic [2:0] KIND_HEX     = 3'd4;
  localparam logic [2:0] KIND_SYMBOL  = 3'd5;

  localparam logic [7:0] CHAR_LOWER_X = 8'h78;

  localparam int KW_NUM = 5;

  typedef logic [7:0][7:0] kw_text_t;

  localparam kw_text_t KW_TEXT [KW_NUM] = '{
    64'h0000_0000_0000_6669,
    64'h0000_0000_6E65_6874,
    64'h0000_0065_6C69_6877,
    64'h0000_0000_0000_6F64,
    64'h0000_0000_6573_6C65
  };

  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd2, 3'd4, 3'd5, 3'd2, 3'd4};

  typedef struct packed {
    logic letter;
    logic dec;
    logic oct;
    logic hex;
    logic space;
    logic zero;
    logic oct_nz;
    logic lower_x;
  } tsc_class_t;

  typedef struct packed {
    logic [7:0] ch;
    tsc_class_t cls;
  } tsc_entry_t;

endpackage

[sv/tsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_front
// Input side: takes text beats and tags each byte with its character class
// before it enters the queue.
// ----------------------------------------------------------------------------
module tsc_front
  import tsc_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       q_full,
  output logic       q_push,
  output tsc_entry_t q_entry
);

  function automatic tsc_class_t classify(input logic [7:0] c);
    tsc_class_t k;
    k.letter  = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    k.dec     = (c >= 8'h30 && c <= 8'h39);
    k.oct     = (c >= 8'h30 && c <= 8'h37);
    k.hex     = k.dec || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    k.space   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    k.zero    = (c == 8'h30);
    k.oct_nz  = (c >= 8'h31 && c <= 8'h37);
    k.lower_x = (c == CHAR_LOWER_X);
    return k;
  endfunction

  assign in_stall    = q_full;
  assign q_push      = in_valid && !q_full;
  assign q_entry.ch  = in_text_byte;
  assign q_entry.cls = classify(in_text_byte);

endmodule

[sv/tsc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_queue
// Short FIFO of classified bytes between the front and the scan engine.
// ----------------------------------------------------------------------------
module tsc_queue
  import tsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tsc_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output tsc_entry_t head
);

  tsc_entry_t           slot_r [QDEPTH];
  logic [QAW-1:0]       wr_ptr_r;
  logic [QAW-1:0]       rd_ptr_r;
  logic [QCW-1:0]       count_r;

  assign full  = (count_r == QCW'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

endmodule

[sv/tsc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_back
// Scan engine: runs the token state machine over queued bytes, keeps the
// token text in a local buffer and plays finished tokens out as result beats.
// ----------------------------------------------------------------------------
module tsc_back
  import tsc_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  tsc_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_text_char,
  output logic       out_truncated,
  output logic       out_token_last
);

  localparam int AW = $clog2(MAX_TOKEN_LEN);
  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_ZERO    = 3'd2;
  localparam logic [2:0] MODE_ZERO_X  = 3'd3;
  localparam logic [2:0] MODE_OCTAL   = 3'd4;
  localparam logic [2:0] MODE_HEX     = 3'd5;
  localparam logic [2:0] MODE_DECIMAL = 3'd6;

  localparam logic [1:0] ST_SCAN = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_SYM  = 2'd3;

  logic [7:0]        mem_r [MAX_TOKEN_LEN];
  logic [7:0]        rdata_r;

  logic [1:0]        state_r, state_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [KW_NUM-1:0] kw_r, kw_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic              trunc_r, trunc_nxt;
  logic              after_x_r, after_x_nxt;
  logic [7:0]        sym_r, sym_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_trunc_r, out_trunc_nxt;
  logic              out_last_r, out_last_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;

  logic              push_en;
  logic [7:0]        push_c;
  logic [LW-1:0]     base_len;
  logic [KW_NUM-1:0] base_kw;
  logic              base_ovf;

  logic              cont;
  logic [2:0]        cont_mode;
  logic              flush;
  logic              out_free;
  logic              is_kw;
  logic              last_char;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_char = ((LW'(idx_r) + LW'(1)) == len_r);

  always_comb begin
    is_kw = 1'b0;
    for (int i = 0; i < KW_NUM; i++) begin
      if (kw_r[i] && (len_r == LW'(KW_LEN[i]))) begin
        is_kw = 1'b1;
      end
    end
    is_kw = is_kw && !ovf_r;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    kw_nxt        = kw_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    trunc_nxt     = trunc_r;
    after_x_nxt   = after_x_r;
    sym_nxt       = sym_r;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_trunc_nxt = out_trunc_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    push_en       = 1'b0;
    push_c        = q_head.ch;
    mem_wdata     = push_c;
    base_len      = len_r;
    base_kw       = kw_r;
    base_ovf      = ovf_r;
    cont          = 1'b0;
    cont_mode     = mode_r;
    flush         = 1'b0;

    unique case (state_r)
      ST_SCAN: begin
        if (!q_empty) begin
          unique case (mode_r)
            MODE_IDLE: begin
              q_pop = 1'b1;
              if (q_head.cls.space) begin
                mode_nxt = MODE_IDLE;
              end else if (q_head.cls.letter || q_head.cls.dec) begin
                push_en  = 1'b1;
                base_len = '0;
                base_kw  = '1;
                base_ovf = 1'b0;
                priority if (q_head.cls.letter) begin
                  mode_nxt = MODE_IDENT;
                end else if (q_head.cls.zero) begin
                  mode_nxt = MODE_ZERO;
                end else begin
                  mode_nxt = MODE_DECIMAL;
                end
              end else begin
                sym_nxt   = q_head.ch;
                state_nxt = ST_SYM;
              end
            end
            MODE_IDENT: begin
              cont = q_head.cls.letter || q_head.cls.dec;
              flush = !cont;
            end
            MODE_ZERO: begin
              priority if (q_head.cls.lower_x) begin
                cont      = 1'b1;
                cont_mode = MODE_ZERO_X;
              end else if (q_head.cls.oct_nz) begin
                cont      = 1'b1;
                cont_mode = MODE_OCTAL;
              end else begin
                flush = 1'b1;
              end
            end
            MODE_ZERO_X: begin
              cont      = q_head.cls.hex;
              cont_mode = MODE_HEX;
              flush     = !cont;
            end
            MODE_OCTAL: begin
              cont  = q_head.cls.oct;
              flush = !cont;
            end
            MODE_HEX: begin
              cont  = q_head.cls.hex;
              flush = !cont;
            end
            MODE_DECIMAL: begin
              cont  = q_head.cls.dec;
              flush = !cont;
            end
            default: begin
              mode_nxt = MODE_IDLE;
            end
          endcase

          if (cont) begin
            q_pop    = 1'b1;
            push_en  = 1'b1;
            mode_nxt = cont_mode;
          end
          if (flush) begin
            idx_nxt     = '0;
            state_nxt   = ST_RD;
            after_x_nxt = (mode_r == MODE_ZERO_X);
            trunc_nxt   = ovf_r && (mode_r != MODE_ZERO_X);
            if (mode_r == MODE_ZERO_X) begin
              len_nxt = LW'(1);
              ovf_nxt = 1'b0;
            end
            unique case (mode_r)
              MODE_IDENT: kind_nxt = is_kw ? KIND_KEYWORD : KIND_IDENT;
              MODE_OCTAL: kind_nxt = KIND_OCTAL;
              MODE_HEX:   kind_nxt = KIND_HEX;
              default:    kind_nxt = KIND_DECIMAL;
            endcase
          end
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_char_nxt  = rdata_r;
          out_trunc_nxt = trunc_r;
          out_last_nxt  = last_char;
          if (last_char) begin
            state_nxt = ST_SCAN;
            if (after_x_r) begin
              push_en  = 1'b1;
              push_c   = CHAR_LOWER_X;
              base_len = '0;
              base_kw  = '1;
              base_ovf = 1'b0;
              mode_nxt = MODE_IDENT;
            end else begin
              len_nxt  = '0;
              ovf_nxt  = 1'b0;
              kw_nxt   = '1;
              mode_nxt = MODE_IDLE;
            end
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_SYM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_SYMBOL;
          out_char_nxt  = sym_r;
          out_trunc_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_SCAN;
      end
    endcase

    if (push_en) begin
      mem_wdata = push_c;
      if (base_len < LW'(MAX_TOKEN_LEN)) begin
        mem_we    = 1'b1;
        mem_waddr = base_len[AW-1:0];
        len_nxt   = base_len + LW'(1);
        ovf_nxt   = base_ovf;
      end else begin
        len_nxt = base_len;
        ovf_nxt = 1'b1;
      end
      for (int i = 0; i < KW_NUM; i++) begin
        kw_nxt[i] = base_kw[i] && (base_len < LW'(KW_LEN[i])) &&
                    (KW_TEXT[i][base_len[2:0]] == push_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem_r[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SCAN;
      mode_r      <= MODE_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      kw_r        <= '1;
      after_x_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      kw_r        <= kw_nxt;
      after_x_r   <= after_x_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    kind_r      <= kind_nxt;
    trunc_r     <= trunc_nxt;
    sym_r       <= sym_nxt;
    out_kind_r  <= out_kind_nxt;
    out_char_r  <= out_char_nxt;
    out_trunc_r <= out_trunc_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_token_kind = out_kind_r;
  assign out_text_char  = out_char_r;
  assign out_truncated  = out_trunc_r;
  assign out_token_last = out_last_r;

endmodule

[sv/token_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_scanner
// Streaming lexical scanner: program text in, one beat per token character
// out, tagged with the token kind.
//
// Input channel: one text byte per beat (in_valid / in_stall). Bytes are
// classified and queued in a four-entry FIFO, so the input keeps flowing
// while a token plays out.
// Output channel: one beat per stored character (out_valid / out_stall),
// with kind, truncated flag and token_last on the final character. Symbols
// come out as single beats.
// The first beat of a token follows the byte that ends it through the read
// state and the output-register load. The scan engine takes a byte that
// extends a token straight from its scan state; a finished token is read
// back from its text buffer character by character (a read state, then an
// output-register load for each); this buffer read loop sets the throughput.
// Reset clears the queue, the scan state and the output valid flag; the text
// buffer needs no clearing. While out_stall is high the current beat holds
// and the engine waits before its next beat; bytes keep queueing until the
// FIFO is full, then in_stall rises.
// ----------------------------------------------------------------------------
module token_scanner
  import tsc_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_text_char,
  output logic       out_truncated,
  output logic       out_token_last
);

  tsc_entry_t push_entry;
  tsc_entry_t head;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;

  tsc_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  tsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (head)
  );

  tsc_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_text_char  (out_text_char),
    .out_truncated  (out_truncated),
    .out_token_last (out_token_last)
  );

endmodule
